// ===== hdl/rre_pkg.sv =====
// Shared types, constants and width helpers for the range run encoder.
package rre_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_PUT   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_ORDER_ERR = 1'b1;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [FIELD_WIDTH-1:0] field_t;

    typedef struct packed {
        logic   need_marker;
        logic   need_run;
        logic   need_delta;
        field_t run_val;
        field_t delta_val;
        logic   status;
        field_t total;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic value_t to_value(input field_t f);
        logic [63:0] t;
        t = 64'(f);
        return t[VALUE_WIDTH-1:0];
    endfunction

    function automatic field_t to_field(input value_t v);
        logic [63:0] t;
        t = 64'(v);
        return t[FIELD_WIDTH-1:0];
    endfunction

endpackage

// ===== hdl/rre_front.sv =====
// Front part: takes transactions, updates the run state and builds a job per item.
module rre_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  command,
    input  rre_pkg::field_t       range_start,
    input  rre_pkg::field_t       range_end,
    input  rre_pkg::queue_status_t q_status,
    output logic                  push,
    output rre_pkg::job_t         push_job
);

    rre_pkg::value_t last_value_reg, last_value_next;
    rre_pkg::value_t open_run_reg, open_run_next;
    rre_pkg::value_t member_count_reg, member_count_next;

    rre_pkg::value_t s, e, len, back_dist, fwd_dist, grow;
    logic            run_some, run_many;

    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    always_comb
    begin
        s         = rre_pkg::to_value(range_start);
        e         = rre_pkg::to_value(range_end);
        len       = e - s;
        back_dist = last_value_reg - s;
        fwd_dist  = s - last_value_reg;
        grow      = e - last_value_reg;
        run_some  = open_run_reg != '0;
        run_many  = run_some && (open_run_reg != rre_pkg::VALUE_WIDTH'(1));

        last_value_next   = last_value_reg;
        open_run_next     = open_run_reg;
        member_count_next = member_count_reg;

        push_job             = '0;
        push_job.status      = rre_pkg::ST_OK;
        push_job.run_val     = rre_pkg::to_field(open_run_reg);
        push_job.delta_val   = rre_pkg::to_field(fwd_dist);

        if (command == rre_pkg::CMD_FLUSH)
        begin
            push_job.need_marker = run_many;
            push_job.need_run    = run_some;
            open_run_next        = '0;
        end
        else if (e < s)
        begin
            push_job.status = rre_pkg::ST_ORDER_ERR;
        end
        else if (s < last_value_reg)
        begin
            if (back_dist > open_run_reg)
            begin
                push_job.status = rre_pkg::ST_ORDER_ERR;
            end
            else if (e > last_value_reg)
            begin
                open_run_next     = open_run_reg + grow;
                member_count_next = member_count_reg + grow;
                last_value_next   = e;
            end
        end
        else if (s == last_value_reg)
        begin
            last_value_next   = e;
            open_run_next     = open_run_reg + len;
            member_count_next = member_count_reg + len;
        end
        else
        begin
            if (fwd_dist == rre_pkg::VALUE_WIDTH'(1))
            begin
                open_run_next = open_run_reg + len + rre_pkg::VALUE_WIDTH'(1);
            end
            else
            begin
                push_job.need_marker = run_many;
                push_job.need_run    = run_some;
                push_job.need_delta  = 1'b1;
                open_run_next        = len;
            end
            last_value_next   = e;
            member_count_next = member_count_reg + len + rre_pkg::VALUE_WIDTH'(1);
        end

        push_job.total = rre_pkg::to_field(member_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_value_reg   <= '0;
            open_run_reg     <= '0;
            member_count_reg <= '0;
        end
        else if (push)
        begin
            last_value_reg   <= last_value_next;
            open_run_reg     <= open_run_next;
            member_count_reg <= member_count_next;
        end
    end

endmodule

// ===== hdl/rre_queue.sv =====
// Job queue between the front and back parts.
module rre_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rre_pkg::job_t          push_job,
    input  logic                   pop,
    output rre_pkg::job_t          pop_job,
    output rre_pkg::queue_status_t q_status
);

    rre_pkg::job_t                    mem_reg [rre_pkg::QUEUE_DEPTH];
    logic [rre_pkg::QPTR_WIDTH-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [rre_pkg::QCNT_WIDTH-1:0]   count_reg, count_next;

    assign q_status.full  = count_reg == rre_pkg::QCNT_WIDTH'(rre_pkg::QUEUE_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign pop_job        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + rre_pkg::QCNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - rre_pkg::QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rre_pkg::QPTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rre_pkg::QPTR_WIDTH'(1);
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full && !pop))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !q_status.empty)
        else $error("queue empty after push");

endmodule

// ===== hdl/rre_back.sv =====
// Back part: plays out each job as one to three result transactions.
module rre_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rre_pkg::queue_status_t q_status,
    input  rre_pkg::job_t          pop_job,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   has_token,
    output rre_pkg::field_t        token_value,
    output logic                   status,
    output rre_pkg::field_t        member_total,
    output logic                   last_of_run
);

    rre_pkg::job_t cur_reg, cur_next;
    logic          cur_valid_reg, cur_valid_next;
    logic          take;

    assign result_valid = cur_valid_reg;
    assign status       = cur_reg.status;
    assign member_total = cur_reg.total;
    assign take         = cur_valid_reg && !result_stall;

    always_comb
    begin
        has_token   = 1'b1;
        token_value = '0;
        cur_next    = cur_reg;
        if (cur_reg.need_marker)
        begin
            cur_next.need_marker = 1'b0;
        end
        else if (cur_reg.need_run)
        begin
            token_value       = cur_reg.run_val;
            cur_next.need_run = 1'b0;
        end
        else if (cur_reg.need_delta)
        begin
            token_value         = cur_reg.delta_val;
            cur_next.need_delta = 1'b0;
        end
        else
        begin
            has_token = 1'b0;
        end
        last_of_run = $countones({cur_reg.need_marker, cur_reg.need_run,
                                  cur_reg.need_delta}) <= 1;

        pop            = !q_status.empty && (!cur_valid_reg || (take && last_of_run));
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_next       = pop_job;
            cur_valid_next = 1'b1;
        end
        else if (take && last_of_run)
        begin
            cur_valid_next = 1'b0;
        end
        else if (!take)
        begin
            cur_next = cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !last_of_run) |=> result_valid)
        else $error("job dropped before its last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !has_token) |-> last_of_run)
        else $error("empty result not last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> !has_token)
        else $error("rejected range carries a token");

endmodule

// ===== hdl/range_run_encoder_top.sv =====
// Top level of the range run encoder.
//
//  channel | direction | handshake                 | payload
//  item    | in        | item_valid / item_stall     | command, range_start, range_end
//  result  | out       | result_valid / result_stall | has_token, token_value, status,
//          |           |                             | member_total, last_of_run
//
// An item is classified and the run state updated in the cycle it is taken.
// Each item yields one to three results, one per cycle on the result port while
// result_stall is low; a four-job queue sits between.
// Reset clears the run state and the queue at once; no clearing pass.
// item_stall rises only while the job queue is full.
module range_run_encoder_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic            command,
    input  rre_pkg::field_t range_start,
    input  rre_pkg::field_t range_end,
    output logic            result_valid,
    input  logic            result_stall,
    output logic            has_token,
    output rre_pkg::field_t token_value,
    output logic            status,
    output rre_pkg::field_t member_total,
    output logic            last_of_run
);

    rre_pkg::queue_status_t q_status;
    rre_pkg::job_t          push_job, pop_job;
    logic                   push, pop;

    rre_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .command     (command),
        .range_start (range_start),
        .range_end   (range_end),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job)
    );

    rre_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    rre_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_job      (pop_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .has_token    (has_token),
        .token_value  (token_value),
        .status       (status),
        .member_total (member_total),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for range_run_encoder_top: directed table, then random ranges.
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 194;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic            has_tok;
        rre_pkg::field_t value;
        logic            stat;
        rre_pkg::field_t total;
        logic            last;
    } token_t;

    typedef struct packed {
        logic            cmd;
        rre_pkg::field_t lo;
        rre_pkg::field_t hi;
        logic            typed;
        logic            stat;
        rre_pkg::field_t total;
    } row_t;

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            item_valid   = 1'b0;
    logic            command      = rre_pkg::CMD_PUT;
    rre_pkg::field_t range_start  = '0;
    rre_pkg::field_t range_end    = '0;
    logic            result_stall = 1'b0;
    logic            item_stall;
    logic            result_valid;
    logic            has_token;
    rre_pkg::field_t token_value;
    logic            status;
    rre_pkg::field_t member_total;
    logic            last_of_run;

    rre_pkg::value_t last_val;
    rre_pkg::value_t run_len;
    rre_pkg::value_t members;
    token_t          step_out [3];
    int              step_n;

    token_t      expected_tokens [$];
    token_t      seen_tok;
    token_t      want_tok;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int unsigned stall_pick;
    logic        quiet = 1'b0;

    range_run_encoder_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .range_start  (range_start),
        .range_end    (range_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .has_token    (has_token),
        .token_value  (token_value),
        .status       (status),
        .member_total (member_total),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic void add_token(input logic tok, input rre_pkg::value_t val);
        step_out[step_n] = '{tok, val, rre_pkg::ST_OK, '0, 1'b0};
        step_n++;
    endfunction

    function automatic void flush_pending();
        if (run_len != 0)
        begin
            if (run_len != 1)
                add_token(1'b1, '0);
            add_token(1'b1, run_len);
            run_len = '0;
        end
    endfunction

    function automatic void encode_item(input logic cmd, input rre_pkg::value_t lo,
                                        input rre_pkg::value_t hi);
        logic bad;
        bad = 1'b0;
        step_n = 0;
        if (cmd == rre_pkg::CMD_FLUSH)
            flush_pending();
        else if (hi < lo)
            bad = 1'b1;
        else if (lo < last_val)
        begin
            if (last_val - lo > run_len)
                bad = 1'b1;
            else if (hi > last_val)
            begin
                run_len = run_len + (hi - last_val);
                members = members + (hi - last_val);
                last_val = hi;
            end
        end
        else if (lo == last_val)
        begin
            run_len = run_len + (hi - lo);
            members = members + (hi - lo);
            last_val = hi;
        end
        else
        begin
            if (lo - last_val == 1)
                run_len = run_len + (hi - lo) + 1;
            else
            begin
                flush_pending();
                add_token(1'b1, lo - last_val);
                run_len = hi - lo;
            end
            members = members + (hi - lo) + 1;
            last_val = hi;
        end
        if (step_n == 0)
            add_token(1'b0, '0);
        for (int k = 0; k < step_n; k++)
        begin
            step_out[k].stat  = bad ? rre_pkg::ST_ORDER_ERR : rre_pkg::ST_OK;
            step_out[k].total = members;
            step_out[k].last  = (k == step_n - 1);
        end
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic cmd, input rre_pkg::field_t lo,
                             input rre_pkg::field_t hi, input logic typed,
                             input logic stat, input rre_pkg::field_t total);
        int gap;
        gap = pick_gap();
        if ($urandom_range(0, 29) == 0)
            quiet = ~quiet;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        range_start <= lo;
        range_end   <= hi;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        encode_item(cmd, rre_pkg::to_value(lo), rre_pkg::to_value(hi));
        if (typed)
            expected_tokens.push_back('{1'b0, '0, stat, total, 1'b1});
        else
            for (int k = 0; k < step_n; k++)
                expected_tokens.push_back(step_out[k]);
    endtask

    task automatic report_mismatch(input string what, input token_t want, input token_t seen);
        fail_count++;
        if (fail_count <= REPORT_MAX)
        begin
            $display("%0t %s: expected tok=%0b val=%h st=%0b total=%h last=%0b",
                     $realtime, what, want.has_tok, want.value, want.stat, want.total,
                     want.last);
            $display("%0t %s: got tok=%0b val=%h st=%0b total=%h last=%0b",
                     $realtime, what, seen.has_tok, seen.value, seen.stat, seen.total,
                     seen.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen_tok = {has_token, token_value, status, member_total, last_of_run};
            if (expected_tokens.size() == 0)
                report_mismatch("unexpected result", '0, seen_tok);
            else
            begin
                want_tok = expected_tokens.pop_front();
                if (seen_tok !== want_tok)
                    report_mismatch("result mismatch", want_tok, seen_tok);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 35)
            begin
                result_stall <= 1'b1;
                stall_left <= (stall_pick < 4) ? $urandom_range(15, 40) : $urandom_range(0, 2);
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left <= (stall_pick > 90) ? $urandom_range(30, 80) : $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[range_run_encoder_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        row_t            script [23];
        int unsigned     r;
        int unsigned     len;
        logic            cmd;
        rre_pkg::value_t lo;
        rre_pkg::value_t hi;

        script = '{
            '{rre_pkg::CMD_FLUSH, 32'd0, 32'd0, 1'b1, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'd0, 1'b1, rre_pkg::ST_ORDER_ERR, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd0, 32'd0, 1'b1, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd1, 32'd3, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd2, 32'd5, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd4, 32'd5, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd10, 32'd12, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd5, 32'd6, 1'b1, rre_pkg::ST_ORDER_ERR, 32'd8},
            '{rre_pkg::CMD_PUT, 32'd13, 32'd13, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd20, 32'd20, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd22, 32'd22, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd23, 32'd23, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd30, 32'd30, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_FLUSH, 32'd0, 32'd0, 1'b1, rre_pkg::ST_OK, 32'd13},
            '{rre_pkg::CMD_PUT, 32'd31, 32'd40, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_FLUSH, 32'd0, 32'd0, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd0, 32'hFFFF_FFFF, 1'b1, rre_pkg::ST_ORDER_ERR, 32'd23},
            '{rre_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, rre_pkg::ST_OK, 32'd23},
            '{rre_pkg::CMD_PUT, 32'd50, 32'd60, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd55, 32'd70, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd70, 32'd75, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd60, 32'd65, 1'b0, rre_pkg::ST_OK, 32'd0},
            '{rre_pkg::CMD_PUT, 32'd40, 32'd50, 1'b0, rre_pkg::ST_OK, 32'd0}
        };
        last_val = '0;
        run_len  = '0;
        members  = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].cmd, script[i].lo, script[i].hi,
                      script[i].typed, script[i].stat, script[i].total);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r   = $urandom_range(0, 99);
            len = $urandom_range(0, 1 << $urandom_range(0, 12));
            cmd = rre_pkg::CMD_PUT;
            lo  = last_val;
            hi  = last_val;
            if (i == RANDOM_ITEMS / 2)
            begin
                lo = last_val + 32'h8000_0000 + $urandom_range(0, 255);
                hi = lo + len;
            end
            else if (r < 10 || last_val > 32'hF000_0000)
            begin
                cmd = rre_pkg::CMD_FLUSH;
                lo  = $urandom();
                hi  = $urandom();
            end
            else if (r < 20)
            begin
                lo = $urandom_range(1, 32'hFFFF_FFFF);
                hi = $urandom_range(0, lo - 1);
            end
            else if (r < 30 && last_val > run_len)
            begin
                lo = $urandom_range(0, last_val - run_len - 1);
                hi = lo + len;
            end
            else if (r < 45)
            begin
                lo = last_val - $urandom_range(0, run_len);
                hi = lo + len;
            end
            else if (r < 60)
                hi = last_val + len;
            else if (r < 75)
            begin
                lo = last_val + 1;
                hi = lo + len;
            end
            else
            begin
                lo = last_val + 2 + $urandom_range(0, 1 << $urandom_range(1, 20));
                hi = lo + len;
            end
            send_item(cmd, lo, hi, 1'b0, rre_pkg::ST_OK, '0);
        end

        // close with the top of the value range
        send_item(rre_pkg::CMD_PUT, last_val + 2, 32'hFFFF_FFFE, 1'b0, rre_pkg::ST_OK, '0);
        send_item(rre_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, rre_pkg::ST_OK, '0);
        send_item(rre_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 32'd0, 1'b0, rre_pkg::ST_OK, '0);
        item_valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("[range_run_encoder_top] OK");
        else
            $display("[range_run_encoder_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rre_pkg.sv
hdl/rre_front.sv
hdl/rre_queue.sv
hdl/rre_back.sv
hdl/range_run_encoder_top.sv
bench/tb.sv
